/* sv/reno_pkg.sv */
// Package: shared constants and controller/datapath command and status types.
`timescale 1ns / 1ps
package reno_pkg;
  localparam logic [1:0] MODE_OPEN     = 2'd0;
  localparam logic [1:0] MODE_DISORDER = 2'd1;
  localparam logic [1:0] MODE_RECOVERY = 2'd2;
  localparam logic [15:0] DUP_LIMIT    = 16'd3;
  localparam logic [31:0] ONE_FIXED    = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_SEGMENT_SIZE   = 2'd0;
  localparam logic [1:0] REG_INIT_WINDOW    = 2'd1;
  localparam logic [1:0] REG_INIT_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_INIT_SEQUENCE  = 2'd3;

  typedef struct packed {
    logic load;      // capture beat, start reciprocal
    logic grow;      // apply cwnd growth
    logic mode_upd;  // apply Reno mode logic
    logic mult;      // window bytes from cwnd * mss
    logic div_start; // start window / mss
    logic finish;    // allowance and output capture
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;
endpackage

/* sv/reno_ack_congestion_control.sv */
// Top level: Reno congestion control, one ACK beat in, one result beat out.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one received ACK per beat (ack number, advertised
//   window, send_next). Output channel out_*: one result beat per ACK.
//   Configuration: cfg_write_enable/cfg_index/cfg_write_data, write only
//   while idle; windows and sequence writes load live state at once.
// Sequence: an accepted ACK runs the reciprocal of cwnd, then growth, mode
//   and window bytes, then starts and runs window/mss and finishes before
//   out_valid; both divisions run for every ACK.
//   A new ACK is taken only once the previous one has finished.
//   The divider, one quotient bit a cycle over 64 steps, paces both divisions.
// Reset: synchronous rst_n low restores registers 1460/1, 16, 0 and clears
//   mode, counters and window; no result is pending.
// Stall: the result holds in its output register while out_stall is high;
//   the next ACK is still taken and processed, and its finished result
//   waits in the last step until the held beat leaves.
module reno_ack_congestion_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_advertised_window,
  input  logic [31:0] in_send_next,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_retransmit_request,
  output logic [1:0]  out_reno_mode,
  output logic        out_window_updated,
  output logic [31:0] out_send_window,
  output logic [31:0] out_send_allowance,
  output logic [31:0] out_congestion_window
);
  import reno_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  logic capture, need_recip;
  logic r_rtx, r_upd;
  logic [1:0] r_mode;
  logic [31:0] r_win, r_allow, r_cwnd, cwnd_now;

  reno_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index),
    .cfg_write_data(cfg_write_data), .in_ack_number(in_ack_number),
    .in_advertised_window(in_advertised_window), .in_send_next(in_send_next),
    .res_retransmit_request(r_rtx), .res_reno_mode(r_mode),
    .res_window_updated(r_upd), .res_send_window(r_win),
    .res_send_allowance(r_allow), .res_congestion_window(r_cwnd)
  );

  assign cwnd_now = r_cwnd;
  assign need_recip = 1'b1;

  reno_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .need_recip(need_recip),
    .cmd(cmd), .stat(stat), .capture(capture)
  );

  logic        o_rtx_r, o_upd_r;
  logic [1:0]  o_mode_r;
  logic [31:0] o_win_r, o_cwnd_r, o_allow_r;
  logic        cap_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_d_r <= 1'b0;
    else cap_d_r <= capture && cmd.finish;
    if (capture && cmd.finish) begin
      o_rtx_r <= r_rtx;
      o_mode_r <= r_mode;
      o_upd_r <= r_upd;
      o_win_r <= r_win;
      o_cwnd_r <= cwnd_now;
    end
  end

  assign o_allow_r = r_allow;
  assign out_retransmit_request = o_rtx_r;
  assign out_reno_mode = o_mode_r;
  assign out_window_updated = o_upd_r;
  assign out_send_window = o_win_r;
  assign out_send_allowance = o_allow_r;
  assign out_congestion_window = o_cwnd_r;

`ifndef SYNTHESIS
  a_cap_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cap_d_r |-> out_valid) else $error("result not presented after capture");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.grow || cmd.mode_upd || cmd.mult) |-> in_stall)
    else $error("input open while an ACK is in flight");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_congestion_window))
    else $error("held result changed");
`endif
endmodule

/* sv/reno_div.sv */
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module reno_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {rem_r, q_r[63]};
    diff = trial - {1'b0, dvs_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = busy_r && (cnt_r == 7'd1);
  assign quotient = q_nxt;
endmodule

/* sv/reno_dp.sv */
// Datapath: congestion state, window math, shared divider and result register.
`timescale 1ns / 1ps
module reno_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  reno_pkg::cmd_t     cmd,
  output reno_pkg::stat_t    stat,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_write_data,
  input  logic [31:0]        in_ack_number,
  input  logic [15:0]        in_advertised_window,
  input  logic [31:0]        in_send_next,
  output logic               res_retransmit_request,
  output logic [1:0]         res_reno_mode,
  output logic               res_window_updated,
  output logic [31:0]        res_send_window,
  output logic [31:0]        res_send_allowance,
  output logic [31:0]        res_congestion_window
);
  import reno_pkg::*;

  logic [15:0] mss_r;
  logic [31:0] cwnd_r, thr_r, oldest_r, mark_r, wbytes_r, allow_r;
  logic [15:0] dup_r;
  logic [1:0]  mode_r;
  logic [31:0] ack_r, snd_r;
  logic [15:0] adv_r;
  logic        rtx_r, upd_r, phase_r;
  logic [31:0] inflight_r;

  logic        div_start, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic [47:0] prod;
  logic [32:0] sum;
  logic [31:0] addend, recip, floor_win, diff, segs;

  assign div_start = cmd.load || cmd.div_start;
  assign div_dvd = cmd.load ? 64'h1_0000_0000 : {32'd0, wbytes_r};
  assign div_dvs = cmd.load ? cwnd_r : {16'd0, mss_r};

  reno_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );
  assign stat.div_done = div_done;

  logic [31:0] q_r;
  always_ff @(posedge clk) if (div_done) q_r <= (div_q[63:32] != '0) ? ALL_ONES : div_q[31:0];

  assign recip = (cwnd_r == '0) ? ALL_ONES : q_r;
  assign addend = (cwnd_r < thr_r) ? ONE_FIXED : recip;
  assign sum = {1'b0, cwnd_r} + {1'b0, addend};
  assign prod = 48'(cwnd_r) * 48'(mss_r);
  assign floor_win = (adv_r > mss_r) ? {16'd0, adv_r} : {16'd0, mss_r};
  assign diff = snd_r - ack_r;
  assign segs = (mss_r == '0) ? '0 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r <= 16'd1460;
      cwnd_r <= 32'd1 << 16;
      thr_r <= 32'd16 << 16;
      oldest_r <= '0;
      dup_r <= '0;
      mark_r <= '0;
      mode_r <= MODE_OPEN;
      wbytes_r <= '0;
      allow_r <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_SEGMENT_SIZE:   mss_r <= cfg_write_data[15:0];
          REG_INIT_WINDOW:    cwnd_r <= {cfg_write_data[15:0], 16'd0};
          REG_INIT_THRESHOLD: thr_r <= {cfg_write_data[15:0], 16'd0};
          REG_INIT_SEQUENCE:  oldest_r <= cfg_write_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        ack_r <= in_ack_number;
        adv_r <= in_advertised_window;
        snd_r <= in_send_next;
        phase_r <= in_ack_number > oldest_r;
        rtx_r <= 1'b0;
      end
      if (cmd.grow && phase_r) cwnd_r <= sum[32] ? ALL_ONES : sum[31:0];
      if (cmd.mode_upd) begin
        case (mode_r)
          MODE_OPEN: if (ack_r == oldest_r) begin
            dup_r <= 16'd1;
            mode_r <= MODE_DISORDER;
          end
          MODE_DISORDER: if (ack_r == oldest_r) begin
            dup_r <= dup_r + 16'd1;
            if (dup_r + 16'd1 == DUP_LIMIT) begin
              mode_r <= MODE_RECOVERY;
              mark_r <= snd_r;
              rtx_r <= 1'b1;
              cwnd_r <= {1'b0, cwnd_r[31:1]};
              thr_r <= {1'b0, cwnd_r[31:1]};
            end
          end else begin
            dup_r <= '0;
            mode_r <= MODE_OPEN;
          end
          MODE_RECOVERY: if (ack_r == oldest_r) begin
            dup_r <= dup_r + 16'd1;
          end else if (ack_r < mark_r) begin
            dup_r <= '0;
            rtx_r <= 1'b1;
          end else begin
            dup_r <= '0;
            mode_r <= MODE_OPEN;
          end
          default: begin
            dup_r <= '0;
            mode_r <= MODE_OPEN;
          end
        endcase
        upd_r <= ack_r <= snd_r;
      end
      if (cmd.mult) begin
        inflight_r <= (diff > {16'd0, dup_r}) ? diff - {16'd0, dup_r} : '0;
        oldest_r <= ack_r;
        if (upd_r) wbytes_r <= (prod[47:16] < floor_win) ? prod[47:16] : floor_win;
      end
      if (cmd.finish && upd_r) allow_r <= (segs > inflight_r) ? segs - inflight_r : '0;
    end
  end

  assign res_retransmit_request = rtx_r;
  assign res_reno_mode = mode_r;
  assign res_window_updated = upd_r;
  assign res_send_window = wbytes_r;
  assign res_send_allowance = allow_r;
  assign res_congestion_window = cwnd_r;
endmodule

/* sv/reno_ctrl.sv */
// Controller: sequences one ACK through reciprocal, growth, mode update, window and division.
`timescale 1ns / 1ps
module reno_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            need_recip,
  output reno_pkg::cmd_t  cmd,
  input  reno_pkg::stat_t stat,
  output logic            capture
);
  import reno_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_RECIP = 3'd1, S_GROW = 3'd2, S_MODE = 3'd3,
                         S_MULT = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6;
  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       wait_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    capture = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1;
        state_nxt = need_recip ? S_RECIP : S_GROW;
      end
      S_RECIP: if (stat.div_done) state_nxt = S_GROW;
      S_GROW: begin cmd.grow = 1'b1; state_nxt = S_MODE; end
      S_MODE: begin cmd.mode_upd = 1'b1; state_nxt = S_MULT; end
      S_MULT: begin cmd.mult = 1'b1; state_nxt = S_DIV; end
      S_DIV: begin
        if (!wait_r) cmd.div_start = 1'b1;
        else if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        capture = 1'b1;
        if (!ov_r || !out_stall) state_nxt = S_IDLE;
        else cmd.finish = 1'b0;
        if (state_nxt == S_IDLE) ov_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      wait_r <= (state_r == S_DIV);
    end
  end
endmodule
